// ===== src/ptns_pkg.sv =====
// Shared types and constants of the point table nearest search block.
package ptns_pkg;

    localparam int COORD_W  = 16;
    localparam int ID_OUT_W = 6;
    localparam int TEAM_W   = 3;
    localparam int LIM_W    = 16;
    localparam int OP_W     = 3;

    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int DIST_W   = SQ_W + 2;
    localparam int LIMSQ_W  = 2 * LIM_W;

    localparam int IN_FIELDS_W  = ID_OUT_W + 3 * COORD_W + TEAM_W + LIM_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ID_OUT_W + 3 * COORD_W + TEAM_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ADD_AUTO = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_AT   = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_FETCH    = 3'd3;
    localparam logic [OP_W-1:0] OP_NEAREST  = 3'd4;

    typedef struct packed {
        logic [TEAM_W-1:0]         team;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic live;
        logic last;
        logic occupied;
    } scan_tag_t;

endpackage

// ===== src/ptns_point_mem.sv =====
// Point store: one write port and one read port with registered read data.
module ptns_point_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  ptns_pkg::point_t    wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output ptns_pkg::point_t    rd_data
);

    ptns_pkg::point_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/ptns_dist.sv =====
// Squared distance pipeline fed by the point store read port.
module ptns_dist #(
    parameter int ID_W = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ptns_pkg::scan_tag_t                  tag_in,
    input  logic [ID_W-1:0]                      id_in,
    input  ptns_pkg::point_t                     point,
    input  logic signed [ptns_pkg::COORD_W-1:0]  qx,
    input  logic signed [ptns_pkg::COORD_W-1:0]  qy,
    input  logic signed [ptns_pkg::COORD_W-1:0]  qz,
    output ptns_pkg::scan_tag_t                  tag_out,
    output logic [ID_W-1:0]                      id_out,
    output logic [ptns_pkg::DIST_W-1:0]          dist_out
);

    ptns_pkg::scan_tag_t tag0_reg, tag1_reg, tag2_reg, tag3_reg;
    logic [ID_W-1:0] id0_reg, id1_reg, id2_reg, id3_reg;
    logic signed [ptns_pkg::DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [ptns_pkg::SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [ptns_pkg::DIST_W-1:0] sum_reg;
    logic signed [2*ptns_pkg::DIFF_W-1:0] px, py, pz;

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag0_reg <= tag_in;
            tag1_reg <= tag0_reg;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        id0_reg <= id_in;
        id1_reg <= id0_reg;
        id2_reg <= id1_reg;
        id3_reg <= id2_reg;
        dx_reg  <= ptns_pkg::DIFF_W'(point.x) - ptns_pkg::DIFF_W'(qx);
        dy_reg  <= ptns_pkg::DIFF_W'(point.y) - ptns_pkg::DIFF_W'(qy);
        dz_reg  <= ptns_pkg::DIFF_W'(point.z) - ptns_pkg::DIFF_W'(qz);
        sqx_reg <= px[ptns_pkg::SQ_W-1:0];
        sqy_reg <= py[ptns_pkg::SQ_W-1:0];
        sqz_reg <= pz[ptns_pkg::SQ_W-1:0];
        sum_reg <= ptns_pkg::DIST_W'(sqx_reg) + ptns_pkg::DIST_W'(sqy_reg)
                 + ptns_pkg::DIST_W'(sqz_reg);
    end

    assign tag_out  = tag3_reg;
    assign id_out   = id3_reg;
    assign dist_out = sum_reg;

endmodule

// ===== src/point_table_nearest_search.sv =====
// Top level of the point table with add, remove, fetch and nearest search.
// Each beat on the input carries one operation and yields exactly one beat on the
// output. Add at a given id, remove and unused operations go straight to the
// result; fetch of a stored id first reads the point store. Add at the lowest
// free id walks the valid marks from id 1 upward, one id per cycle. A nearest query
// reads every slot of the point store through its single read port, one per cycle,
// then drains the distance pipeline and reads the winner back. One operation is in
// flight at a time; a result waiting on the output does not block acceptance of
// the next operation.
module point_table_nearest_search #(
    parameter int ID_LIMIT = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // entry_id, coord_x, coord_y, coord_z, team_tag, near_limit, zero fill
    input  logic [ptns_pkg::IN_DATA_W-1:0]      s_tdata,
    // opcode
    input  logic [ptns_pkg::OP_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // result_id, point_x, point_y, point_z, point_team, zero fill
    output logic [ptns_pkg::OUT_DATA_W-1:0]     m_tdata,
    // ok
    output logic                                m_tuser
);

    localparam int ID_W  = (ID_LIMIT > 1) ? $clog2(ID_LIMIT) : 1;
    localparam int CMP_W = ((ID_W > ptns_pkg::ID_OUT_W) ? ID_W : ptns_pkg::ID_OUT_W) + 1;
    localparam logic [ID_W-1:0] LAST_ID = ID_W'(ID_LIMIT - 1);

    localparam int CW  = ptns_pkg::COORD_W;
    localparam int X_L = ptns_pkg::ID_OUT_W;
    localparam int Y_L = X_L + CW;
    localparam int Z_L = Y_L + CW;
    localparam int T_L = Z_L + CW;
    localparam int L_L = T_L + ptns_pkg::TEAM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_SCAN,
        ST_DRAIN,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [ID_LIMIT-1:0] slot_valid_reg;

    logic [ptns_pkg::ID_OUT_W-1:0] in_id;
    ptns_pkg::point_t              in_point;
    logic [ptns_pkg::LIM_W-1:0]    in_lim;
    logic                          s_fire;
    logic                          in_range;
    logic [ID_W-1:0]               in_idx;
    logic                          add_at_ok;

    ptns_pkg::point_t            q_reg;
    logic [ptns_pkg::LIMSQ_W-1:0] lim_sq_reg;
    logic                        lim_nz_reg;

    logic [ID_W-1:0] free_idx_reg;
    logic [ID_W-1:0] scan_idx_reg;
    logic [ID_W-1:0] rd_idx_reg;
    logic [ID_W-1:0] best_idx_reg;
    logic [ptns_pkg::DIST_W-1:0] best_dist_reg;
    logic have_reg;
    logic stop_reg;

    logic                          res_ok_reg;
    logic [ptns_pkg::ID_OUT_W-1:0] res_id_reg;
    ptns_pkg::point_t              res_pt_reg;

    logic                          out_valid_reg;
    logic                          out_ok_reg;
    logic [ptns_pkg::ID_OUT_W-1:0] out_id_reg;
    ptns_pkg::point_t              out_pt_reg;

    logic             mem_wr_en;
    logic [ID_W-1:0]  mem_wr_addr;
    ptns_pkg::point_t mem_wr_data;
    logic [ID_W-1:0]  mem_rd_addr;
    ptns_pkg::point_t mem_rd_data;

    ptns_pkg::scan_tag_t issue_tag;
    ptns_pkg::scan_tag_t cmp_tag;
    logic [ID_W-1:0]     cmp_id;
    logic [ptns_pkg::DIST_W-1:0] cmp_dist;
    logic                cmp_take;
    logic                free_hit;

    assign in_id          = s_tdata[X_L-1:0];
    assign in_point.x     = s_tdata[Y_L-1:X_L];
    assign in_point.y     = s_tdata[Z_L-1:Y_L];
    assign in_point.z     = s_tdata[T_L-1:Z_L];
    assign in_point.team  = s_tdata[L_L-1:T_L];
    assign in_lim         = s_tdata[L_L+ptns_pkg::LIM_W-1:L_L];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign in_range  = CMP_W'(in_id) < CMP_W'(ID_LIMIT);
    assign in_idx    = ID_W'(in_id);
    assign add_at_ok = in_range && (in_id != '0) && !slot_valid_reg[in_idx];
    assign free_hit  = (state_reg == ST_FREE) && !slot_valid_reg[free_idx_reg];

    assign mem_wr_en   = (s_fire && (s_tuser == ptns_pkg::OP_ADD_AT) && add_at_ok) || free_hit;
    assign mem_wr_addr = free_hit ? free_idx_reg : in_idx;
    assign mem_wr_data = free_hit ? q_reg : in_point;
    assign mem_rd_addr = (state_reg == ST_SCAN) ? scan_idx_reg : rd_idx_reg;

    assign issue_tag.live     = (state_reg == ST_SCAN);
    assign issue_tag.last     = (scan_idx_reg == LAST_ID);
    assign issue_tag.occupied = slot_valid_reg[scan_idx_reg];

    assign cmp_take = cmp_tag.live && cmp_tag.occupied && !stop_reg
                   && (!have_reg || (cmp_dist < best_dist_reg));

    ptns_point_mem #(
        .DEPTH  (ID_LIMIT),
        .ADDR_W (ID_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ptns_dist #(
        .ID_W (ID_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag_in   (issue_tag),
        .id_in    (scan_idx_reg),
        .point    (mem_rd_data),
        .qx       (q_reg.x),
        .qy       (q_reg.y),
        .qz       (q_reg.z),
        .tag_out  (cmp_tag),
        .id_out   (cmp_id),
        .dist_out (cmp_dist)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            q_reg          <= '0;
            lim_sq_reg     <= '0;
            lim_nz_reg     <= 1'b0;
            free_idx_reg   <= '0;
            scan_idx_reg   <= '0;
            rd_idx_reg     <= '0;
            best_idx_reg   <= '0;
            best_dist_reg  <= '0;
            have_reg       <= 1'b0;
            stop_reg       <= 1'b0;
            res_ok_reg     <= 1'b0;
            res_id_reg     <= '0;
            res_pt_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_ok_reg     <= 1'b0;
            out_id_reg     <= '0;
            out_pt_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            if ((state_reg == ST_SCAN || state_reg == ST_DRAIN) && cmp_take)
            begin
                have_reg      <= 1'b1;
                best_idx_reg  <= cmp_id;
                best_dist_reg <= cmp_dist;
                if (lim_nz_reg && (cmp_dist <= ptns_pkg::DIST_W'(lim_sq_reg)))
                begin
                    stop_reg <= 1'b1;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        q_reg      <= in_point;
                        res_pt_reg <= '0;
                        unique case (s_tuser)
                            ptns_pkg::OP_ADD_AUTO:
                            begin
                                res_ok_reg   <= 1'b0;
                                res_id_reg   <= '0;
                                free_idx_reg <= ID_W'(1);
                                state_reg    <= ST_FREE;
                            end
                            ptns_pkg::OP_ADD_AT:
                            begin
                                if (add_at_ok)
                                begin
                                    slot_valid_reg[in_idx] <= 1'b1;
                                    res_ok_reg             <= 1'b1;
                                    res_id_reg             <= in_id;
                                end
                                else
                                begin
                                    res_ok_reg <= 1'b0;
                                    res_id_reg <= '0;
                                end
                                state_reg <= ST_EMIT;
                            end
                            ptns_pkg::OP_REMOVE:
                            begin
                                if (in_range)
                                begin
                                    slot_valid_reg[in_idx] <= 1'b0;
                                end
                                res_ok_reg <= 1'b1;
                                res_id_reg <= in_id;
                                state_reg  <= ST_EMIT;
                            end
                            ptns_pkg::OP_FETCH:
                            begin
                                res_ok_reg <= 1'b0;
                                if (in_range && slot_valid_reg[in_idx])
                                begin
                                    rd_idx_reg <= in_idx;
                                    res_id_reg <= in_id;
                                    state_reg  <= ST_RD_ISSUE;
                                end
                                else
                                begin
                                    res_id_reg <= '0;
                                    state_reg  <= ST_EMIT;
                                end
                            end
                            ptns_pkg::OP_NEAREST:
                            begin
                                res_ok_reg   <= 1'b0;
                                res_id_reg   <= '0;
                                lim_sq_reg   <= ptns_pkg::LIMSQ_W'(in_lim)
                                              * ptns_pkg::LIMSQ_W'(in_lim);
                                lim_nz_reg   <= (in_lim != '0);
                                scan_idx_reg <= '0;
                                have_reg     <= 1'b0;
                                stop_reg     <= 1'b0;
                                state_reg    <= ST_SCAN;
                            end
                            default:
                            begin
                                res_ok_reg <= 1'b0;
                                res_id_reg <= '0;
                                state_reg  <= ST_EMIT;
                            end
                        endcase
                    end
                end

                ST_FREE:
                begin
                    if (free_hit)
                    begin
                        slot_valid_reg[free_idx_reg] <= 1'b1;
                        res_ok_reg <= 1'b1;
                        res_id_reg <= ptns_pkg::ID_OUT_W'(free_idx_reg);
                        state_reg  <= ST_EMIT;
                    end
                    else if (free_idx_reg == LAST_ID)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        free_idx_reg <= free_idx_reg + 1'b1;
                    end
                end

                ST_SCAN:
                begin
                    if (scan_idx_reg == LAST_ID)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end

                ST_DRAIN:
                begin
                    if (cmp_tag.live && cmp_tag.last)
                    begin
                        if (cmp_take)
                        begin
                            rd_idx_reg <= cmp_id;
                            res_id_reg <= ptns_pkg::ID_OUT_W'(cmp_id);
                            state_reg  <= ST_RD_ISSUE;
                        end
                        else if (have_reg)
                        begin
                            rd_idx_reg <= best_idx_reg;
                            res_id_reg <= ptns_pkg::ID_OUT_W'(best_idx_reg);
                            state_reg  <= ST_RD_ISSUE;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end

                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_WAIT;
                end

                ST_RD_WAIT:
                begin
                    res_ok_reg <= 1'b1;
                    res_pt_reg <= mem_rd_data;
                    state_reg  <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ok_reg    <= res_ok_reg;
                        out_id_reg    <= res_id_reg;
                        out_pt_reg    <= res_pt_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {(ptns_pkg::OUT_DATA_W - ptns_pkg::OUT_FIELDS_W)'(0),
                       out_pt_reg.team, out_pt_reg.z, out_pt_reg.y, out_pt_reg.x,
                       out_id_reg};

    a_slot_zero_unused: assert property (@(posedge clk) disable iff (!rst_n)
        !slot_valid_reg[0])
        else $error("slot zero marked valid");

    a_best_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN || state_reg == ST_DRAIN) && have_reg)
        |-> slot_valid_reg[best_idx_reg])
        else $error("nearest candidate points at an empty slot");

    a_stop_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> have_reg)
        else $error("early stop without a candidate");

    a_tags_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_tag.live |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("distance pipeline busy outside a nearest query");

endmodule

// ===== bench/tb_point_table_nearest_search.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the point table, scored against a behavioral table.
module tb_point_table_nearest_search;

    localparam int SLOTS = 64;
    localparam logic [ptns_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [ptns_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam int PT_W    = $bits(ptns_pkg::point_t);
    localparam int PT_LO   = ptns_pkg::ID_OUT_W;
    localparam int LIM_LO  = PT_LO + PT_W;
    localparam int DRAIN_CYCLES = SLOTS + 24;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 100;
    // Cumulative percentages for add auto, add at, remove, fetch and nearest; the rest is spare.
    localparam int OP_CUTS [3][5] = '{'{35, 60, 65, 80, 98},
                                      '{15, 30, 50, 70, 98},
                                      '{ 5, 10, 60, 75, 98}};

    typedef struct {
        bit                          ok;
        bit [ptns_pkg::ID_OUT_W-1:0] rid;
        ptns_pkg::point_t            pt;
    } reply_t;

    class table_scoreboard;
        bit               slot_used [SLOTS];
        ptns_pkg::point_t slot_pt [SLOTS];
        reply_t           pending_replies [$];
        int unsigned      fail_count;

        function void note_request(logic [ptns_pkg::OP_W-1:0] op,
                                   logic [ptns_pkg::ID_OUT_W-1:0] id, ptns_pkg::point_t p,
                                   logic [ptns_pkg::LIM_W-1:0] lim);
            reply_t r;
            longint dx, dy, dz, d, best_d, lim_sq;
            int     best;
            bit     have;
            r = '{ok: 1'b0, rid: '0, pt: '0};
            case (op)
                ptns_pkg::OP_ADD_AUTO:
                    for (int s = 1; s < SLOTS; s++)
                    begin
                        if (!slot_used[s])
                        begin
                            slot_used[s] = 1'b1;
                            slot_pt[s] = p;
                            r.ok = 1'b1;
                            r.rid = ptns_pkg::ID_OUT_W'(s);
                            break;
                        end
                    end
                ptns_pkg::OP_ADD_AT:
                    if (id != 0 && !slot_used[id])
                    begin
                        slot_used[id] = 1'b1;
                        slot_pt[id] = p;
                        r.ok = 1'b1;
                        r.rid = id;
                    end
                ptns_pkg::OP_REMOVE:
                begin
                    slot_used[id] = 1'b0;
                    r.ok = 1'b1;
                    r.rid = id;
                end
                ptns_pkg::OP_FETCH:
                    if (slot_used[id])
                    begin
                        r.ok = 1'b1;
                        r.rid = id;
                        r.pt = slot_pt[id];
                    end
                ptns_pkg::OP_NEAREST:
                begin
                    have = 1'b0;
                    best = 0;
                    best_d = 0;
                    lim_sq = longint'(lim) * longint'(lim);
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (slot_used[s])
                        begin
                            dx = longint'(slot_pt[s].x) - longint'(p.x);
                            dy = longint'(slot_pt[s].y) - longint'(p.y);
                            dz = longint'(slot_pt[s].z) - longint'(p.z);
                            d = dx * dx + dy * dy + dz * dz;
                            if (!have || d < best_d)
                            begin
                                have = 1'b1;
                                best = s;
                                best_d = d;
                                if (lim != 0 && d <= lim_sq)
                                    break;
                            end
                        end
                    end
                    if (have)
                    begin
                        r.ok = 1'b1;
                        r.rid = ptns_pkg::ID_OUT_W'(best);
                        r.pt = slot_pt[best];
                    end
                end
                default:
                    r.ok = 1'b0;
            endcase
            pending_replies.push_back(r);
        endfunction

        function void match_field(string what, longint unsigned expv, longint unsigned actv);
            if (expv != actv)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, expv, actv);
                fail_count++;
            end
        endfunction

        function void check_reply(logic ok, logic [ptns_pkg::OUT_DATA_W-1:0] data);
            reply_t e;
            ptns_pkg::point_t a;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result beat, ok %0b, data %0h", $time, ok, data);
                fail_count++;
                return;
            end
            e = pending_replies.pop_front();
            a = ptns_pkg::point_t'(data[PT_LO +: PT_W]);
            match_field("ok", e.ok, ok);
            match_field("result_id", e.rid, data[ptns_pkg::ID_OUT_W-1:0]);
            match_field("point_x", e.pt.x, a.x);
            match_field("point_y", e.pt.y, a.y);
            match_field("point_z", e.pt.z, a.z);
            match_field("point_team", e.pt.team, a.team);
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ptns_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [ptns_pkg::OP_W-1:0]       s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ptns_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tuser;

    bit quiet_src = 1'b0;
    bit quiet_sink = 1'b0;
    logic [ptns_pkg::COORD_W-1:0] coord_pool [8];
    table_scoreboard board = new;

    point_table_nearest_search #(.ID_LIMIT(SLOTS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("point_table_nearest_search verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_request(s_tuser, s_tdata[ptns_pkg::ID_OUT_W-1:0],
                               ptns_pkg::point_t'(s_tdata[PT_LO +: PT_W]),
                               s_tdata[LIM_LO +: ptns_pkg::LIM_W]);
        if (rst_n && m_tvalid && m_tready)
            board.check_reply(m_tuser, m_tdata);
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet_sink)
                m_tready <= 1'b1;
            else if ($urandom_range(99) < 2)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(15, 40)) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) < 70);
        end
    end

    function automatic ptns_pkg::point_t mk_point(logic [ptns_pkg::COORD_W-1:0] x,
                                                  logic [ptns_pkg::COORD_W-1:0] y,
                                                  logic [ptns_pkg::COORD_W-1:0] z,
                                                  logic [ptns_pkg::TEAM_W-1:0] team);
        ptns_pkg::point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.team = team;
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet_src || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [ptns_pkg::COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 8)
        begin
            case ($urandom_range(3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        if (r < 40)
            return coord_pool[$urandom_range(7)];
        if (r < 60)
            return ptns_pkg::COORD_W'(int'($urandom_range(0, 127)) - 64);
        return ptns_pkg::COORD_W'($urandom);
    endfunction

    function automatic logic [ptns_pkg::LIM_W-1:0] rand_limit();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return '0;
        if (r < 65)
            return ptns_pkg::LIM_W'($urandom_range(1, 64));
        if (r < 75)
            return ptns_pkg::LIM_W'($urandom_range(1, 1024));
        if (r < 95)
            return ptns_pkg::LIM_W'($urandom);
        return 16'hFFFF;
    endfunction

    // Drives one beat, waits for its handshake, then idles the source for a random gap.
    task automatic send_op(logic [ptns_pkg::OP_W-1:0] op, logic [ptns_pkg::ID_OUT_W-1:0] id,
                           ptns_pkg::point_t p, logic [ptns_pkg::LIM_W-1:0] lim);
        logic [ptns_pkg::IN_DATA_W-1:0] word;
        int gap;
        word = '0;
        word[ptns_pkg::ID_OUT_W-1:0] = id;
        word[PT_LO +: PT_W] = p;
        word[LIM_LO +: ptns_pkg::LIM_W] = lim;
        s_tdata <= word;
        s_tuser <= op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(int profile);
        int r;
        logic [ptns_pkg::OP_W-1:0] op;
        r = $urandom_range(99);
        if (r < OP_CUTS[profile][0])
            op = ptns_pkg::OP_ADD_AUTO;
        else if (r < OP_CUTS[profile][1])
            op = ptns_pkg::OP_ADD_AT;
        else if (r < OP_CUTS[profile][2])
            op = ptns_pkg::OP_REMOVE;
        else if (r < OP_CUTS[profile][3])
            op = ptns_pkg::OP_FETCH;
        else if (r < OP_CUTS[profile][4])
            op = ptns_pkg::OP_NEAREST;
        else
            op = ptns_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        send_op(op, ptns_pkg::ID_OUT_W'($urandom_range(SLOTS - 1)),
                mk_point(rand_coord(), rand_coord(), rand_coord(),
                         ptns_pkg::TEAM_W'($urandom_range(7))),
                rand_limit());
    endtask

    initial
    begin
        int profile;
        foreach (coord_pool[i])
            coord_pool[i] = ptns_pkg::COORD_W'($urandom);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_op(ptns_pkg::OP_NEAREST, 6'd0, mk_point(16'h0000, 16'h0000, 16'h0000, 3'd0), 16'd0);
        send_op(ptns_pkg::OP_FETCH, 6'd5, mk_point(16'h0000, 16'h0000, 16'h0000, 3'd0), 16'd0);
        send_op(ptns_pkg::OP_REMOVE, 6'd7, mk_point(16'h0000, 16'h0000, 16'h0000, 3'd0), 16'd0);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_op(ptns_pkg::OP_W'(op), 6'd63, mk_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7),
                    16'hFFFF);
        send_op(ptns_pkg::OP_ADD_AT, 6'd0, mk_point(16'h0010, 16'h0020, 16'h0030, 3'd2), 16'd0);
        send_op(ptns_pkg::OP_ADD_AUTO, 6'd0, mk_point(16'h7FFF, 16'h8000, 16'h0000, 3'd7), 16'd0);
        send_op(ptns_pkg::OP_ADD_AT, 6'd63, mk_point(16'h8000, 16'h7FFF, 16'hFFFF, 3'd0), 16'd0);
        send_op(ptns_pkg::OP_ADD_AT, 6'd63, mk_point(16'h0001, 16'h0001, 16'h0001, 3'd5), 16'd0);
        send_op(ptns_pkg::OP_ADD_AUTO, 6'd0, mk_point(16'h7FFF, 16'h8000, 16'h0000, 3'd3), 16'd0);
        send_op(ptns_pkg::OP_FETCH, 6'd63, mk_point(16'h0000, 16'h0000, 16'h0000, 3'd0), 16'd0);
        send_op(ptns_pkg::OP_FETCH, 6'd1, mk_point(16'h0000, 16'h0000, 16'h0000, 3'd0), 16'd0);
        // Two stored points at the same spot: the lower id must win.
        send_op(ptns_pkg::OP_NEAREST, 6'd0, mk_point(16'h7FFF, 16'h8000, 16'h0000, 3'd0), 16'd0);
        send_op(ptns_pkg::OP_ADD_AT, 6'd10, mk_point(16'd100, 16'd100, 16'd100, 3'd1), 16'd0);
        send_op(ptns_pkg::OP_ADD_AT, 6'd11, mk_point(16'd101, 16'd100, 16'd100, 3'd4), 16'd0);
        send_op(ptns_pkg::OP_ADD_AT, 6'd12, mk_point(16'd100, 16'd100, 16'd100, 3'd6), 16'd0);
        send_op(ptns_pkg::OP_NEAREST, 6'd0, mk_point(16'h0000, 16'h0000, 16'h0000, 3'd0), 16'd0);
        // The widest threshold accepts the very first candidate.
        send_op(ptns_pkg::OP_NEAREST, 6'd0, mk_point(16'h0000, 16'h0000, 16'h0000, 3'd0),
                16'hFFFF);
        send_op(ptns_pkg::OP_NEAREST, 6'd0, mk_point(16'd100, 16'd100, 16'd100, 3'd0), 16'd1);
        send_op(ptns_pkg::OP_REMOVE, 6'd10, mk_point(16'h0000, 16'h0000, 16'h0000, 3'd0), 16'd0);
        send_op(ptns_pkg::OP_NEAREST, 6'd0, mk_point(16'h0000, 16'h0000, 16'h0000, 3'd0), 16'd0);
        // A threshold hit on id 11 stops the scan before the closer id 12.
        send_op(ptns_pkg::OP_NEAREST, 6'd0, mk_point(16'h0000, 16'h0000, 16'h0000, 3'd0),
                16'd200);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            profile = (ph % 4 == 0) ? 0 : (ph % 4 == 2) ? 2 : 1;
            quiet_src = (ph == 5);
            quiet_sink = (ph == 5 || ph == 9);
            coord_pool[$urandom_range(7)] = ptns_pkg::COORD_W'($urandom);
            repeat (PHASE_ITEMS) send_random(profile);
        end
        quiet_src = 1'b0;
        quiet_sink = 1'b0;
        s_tvalid <= 1'b0;

        while (board.pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.fail_count == 0 && board.pending_replies.size() == 0)
            $display("point_table_nearest_search verification clean");
        else
            $display("point_table_nearest_search verification failed");
        $finish;
    end

endmodule

// ===== point_table_nearest_search.f =====
src/ptns_pkg.sv
src/ptns_point_mem.sv
src/ptns_dist.sv
src/point_table_nearest_search.sv
bench/tb_point_table_nearest_search.sv
